[hw/rtl/mei_pkg.sv]
package mei_pkg;

  localparam int VERTEX_W = 16;
  localparam int FACE_W   = 16;
  localparam int RESULT_W = 10;
  localparam int IN_W     = 2 * VERTEX_W + FACE_W;
  localparam int OUT_W    = 16;
  localparam int USER_W   = 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } mei_state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } mei_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } mei_status_t;

endpackage

[hw/rtl/mesh_edge_table_insert.sv]
// Mesh edge table insert.
// Each input word on the s_ channel carries one triangle edge: two vertex
// indices and the face that contributes it. The block looks the unordered
// vertex pair up in its edge table. On a hit the face becomes that edge's
// second face; on a miss a new edge is appended with the face as its first
// face. Each input word yields exactly one output word on the m_ channel,
// giving the edge index and whether the edge was created or the table was
// full (overflow, nothing stored, index 0).
// One word is handled at a time: after acceptance the block scans the
// stored edges, then writes the result register, and the next word can be
// taken once the result is registered. A miss scans every stored pair, a
// hit stops at its match. The scan reads one stored vertex pair per cycle
// from the pair memory's single read port, from the newest entry down.
// s_tready is high only while idle.
// Reset empties the table at once (edge count to zero) and drops any
// pending result. If the receiver stalls, the result waits in the output
// register and the next word is taken, but its result is held back until
// the previous one has been taken.
module mesh_edge_table_insert
  import mei_pkg::*;
#(
  parameter int EDGE_CAPACITY = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,   // vertex_a[15:0], vertex_b[31:16], face_id[47:32]
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,   // edge_index[9:0], zero fill[15:10]
  output logic [USER_W-1:0] m_tuser    // created[0], overflow[1]
);

  mei_cmd_t    cmd;
  mei_status_t stat;

  mei_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mei_datapath #(
    .EDGE_CAPACITY (EDGE_CAPACITY)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .cmd      (cmd),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

[hw/rtl/mei_ctrl.sv]
module mei_ctrl
  import mei_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  mei_status_t stat,
  output mei_cmd_t    cmd
);

  mei_state_t state;
  mei_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        // No word is taken while reset is held.
        if (!rst) begin
          s_tready = 1'b1;
          if (s_tvalid) begin
            cmd.load   = 1'b1;
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/mei_datapath.sv]
module mei_datapath
  import mei_pkg::*;
#(
  parameter int EDGE_CAPACITY = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [IN_W-1:0]   s_tdata,
  input  mei_cmd_t          cmd,
  output mei_status_t       stat,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,
  output logic [USER_W-1:0] m_tuser
);

  localparam int IW = (EDGE_CAPACITY > 1) ? $clog2(EDGE_CAPACITY) : 1;
  localparam int CW = $clog2(EDGE_CAPACITY + 1);
  localparam int XW = IW + RESULT_W;
  localparam logic [CW-1:0] CAP_C = CW'(EDGE_CAPACITY);

  // Vertex pairs are packed {end, start}; the face stores are never read back.
  logic [2*VERTEX_W-1:0] pair_mem [EDGE_CAPACITY];
  logic [FACE_W-1:0]     face_one_mem [EDGE_CAPACITY];
  logic [FACE_W:0]       face_two_mem [EDGE_CAPACITY];

  logic [VERTEX_W-1:0] va;
  logic [VERTEX_W-1:0] vb;
  logic [FACE_W-1:0]   face;
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_m1;
  logic [IW-1:0]       addr;
  logic                more;
  logic                rd_valid;
  logic [IW-1:0]       rd_tag;
  logic [2*VERTEX_W-1:0] rd_data;
  logic                found;
  logic [IW-1:0]       found_idx;
  logic                match;
  logic                has_room;
  logic                append;
  logic [IW-1:0]       res_idx;
  logic [XW-1:0]       res_wide;
  logic [RESULT_W-1:0] out_idx;
  logic                out_created;
  logic                out_overflow;

  assign count_m1 = count - CW'(1);
  assign has_room = (count < CAP_C);
  assign append   = cmd.commit && !found && has_room;

  assign match = ((rd_data[VERTEX_W-1:0] == va) && (rd_data[2*VERTEX_W-1:VERTEX_W] == vb)) ||
                 ((rd_data[VERTEX_W-1:0] == vb) && (rd_data[2*VERTEX_W-1:VERTEX_W] == va));

  // The scan runs from the top entry down, so the first hit is the last match.
  always_ff @(posedge clk) begin
    if (rst) begin
      more     <= 1'b0;
      rd_valid <= 1'b0;
      found    <= 1'b0;
    end else if (cmd.load) begin
      more     <= (count != '0);
      rd_valid <= 1'b0;
      found    <= 1'b0;
    end else if (cmd.scan) begin
      if (rd_valid && match) begin
        found    <= 1'b1;
        more     <= 1'b0;
        rd_valid <= 1'b0;
      end else begin
        rd_valid <= more;
        if (more && (addr == '0)) begin
          more <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      va   <= s_tdata[VERTEX_W-1:0];
      vb   <= s_tdata[2*VERTEX_W-1:VERTEX_W];
      face <= s_tdata[IN_W-1:2*VERTEX_W];
      addr <= count_m1[IW-1:0];
    end else if (cmd.scan && more) begin
      addr   <= addr - IW'(1);
      rd_tag <= addr;
    end
    if (cmd.scan && rd_valid && match) begin
      found_idx <= rd_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan && more) begin
      rd_data <= pair_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (append) begin
      pair_mem[count[IW-1:0]]     <= {vb, va};
      face_one_mem[count[IW-1:0]] <= face;
      face_two_mem[count[IW-1:0]] <= {1'b0, {FACE_W{1'b0}}};
    end else if (cmd.commit && found) begin
      face_two_mem[found_idx] <= {1'b1, face};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (append) begin
      count <= count + CW'(1);
    end
  end

  assign res_idx  = found ? found_idx : (has_room ? count[IW-1:0] : '0);
  assign res_wide = XW'(res_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_idx      <= res_wide[RESULT_W-1:0];
      out_created  <= !found && has_room;
      out_overflow <= !found && !has_room;
    end
  end

  assign m_tdata = {{(OUT_W - RESULT_W){1'b0}}, out_idx};
  assign m_tuser = {out_overflow, out_created};

  assign stat.scan_done = !more && !rd_valid;
  assign stat.out_free  = !m_tvalid || m_tready;

endmodule

[hw/rtl/mei_checker.sv]
module mei_checker
  import mei_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              s_tvalid,
  input logic              s_tready,
  input logic [IN_W-1:0]   s_tdata,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [OUT_W-1:0]  m_tdata,
  input logic [USER_W-1:0] m_tuser
);

  // A word in work blocks the input until its result is committed.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted again right after a word was accepted");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("created and overflow both set");

  a_overflow_index: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> (m_tdata == '0))
    else $error("overflow result carries a nonzero index");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled output word changed or vanished");

endmodule

bind mesh_edge_table_insert mei_checker u_mei_checker (.*);
